>>> hdl/pool_pkg.sv
package pool_pkg;
  localparam int MaxWidth  = 1024;
  localparam int MaxStride = 8;
  localparam int SampleBits = 16;
  localparam int MaxChannels = 1024;
  localparam int ColBits = $clog2(MaxWidth);
  localparam int AccBits = 28;

  localparam logic [2:0] CfgWidth   = 3'd0;
  localparam logic [2:0] CfgHeight  = 3'd1;
  localparam logic [2:0] CfgStrideX = 3'd2;
  localparam logic [2:0] CfgStrideY = 3'd3;
  localparam logic [2:0] CfgChan    = 3'd4;
  localparam logic [2:0] CfgMode    = 3'd5;

  typedef struct packed {
    logic [10:0] w;
    logic [10:0] h;
    logic [3:0]  sx;
    logic [3:0]  sy;
    logic [10:0] ch;
    logic        mode;
  } cfg_t;

  // command from controller to datapath
  typedef struct packed {
    logic              take;      // sample accepted this cycle
    logic              in_win;    // sample lies in a complete window
    logic [ColBits-1:0] wx;       // window column
    logic [2:0]        ox;
    logic [2:0]        oy;
    logic              row_end;   // ox == sx-1
    logic              col_first; // oy == 0
    logic              win_end;   // bottom-right sample
    logic              pl;
    logic              fl;
  } cmd_t;

  typedef struct packed {
    logic busy;  // pipeline holds an item
    logic full;  // output register holds an item
  } sts_t;

  function automatic logic [10:0] clamp11(input logic [10:0] v, input int hi);
    if (v == '0) return 11'd1;
    if (int'(v) > hi) return 11'(hi);
    return v;
  endfunction

  function automatic logic [3:0] clamp4(input logic [3:0] v);
    if (v == '0) return 4'd1;
    if (int'(v) > MaxStride) return 4'(MaxStride);
    return v;
  endfunction
endpackage

>>> hdl/pool_ctrl.sv
module pool_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pool_pkg::cfg_t    cfg_i,
  input  logic              restart_i,
  input  logic              s_valid_i,
  input  pool_pkg::sts_t    sts_i,
  output logic              s_ready_o,
  output pool_pkg::cmd_t    cmd_o
);
  import pool_pkg::*;

  typedef enum logic [1:0] {
    StRun  = 2'b01,
    StWait = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [9:0] col_q, col_d, row_q, row_d, chn_q, chn_d;
  logic [2:0] ox_q, ox_d, oy_q, oy_d;
  logic [ColBits-1:0] wx_q, wx_d;
  logic [10:0] w, h, ch, spx, spy;
  logic [3:0] sx, sy;
  logic take;

  always_comb begin
    w  = clamp11(cfg_i.w, MaxWidth);
    h  = clamp11(cfg_i.h, MaxWidth);
    ch = clamp11(cfg_i.ch, MaxChannels);
    sx = clamp4(cfg_i.sx);
    sy = clamp4(cfg_i.sy);
  end

  // span of complete windows, held in registers so the compare path stays short
  logic [10:0] spx_q, spy_q, cx_q, cy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spx_q <= '0; spy_q <= '0; cx_q <= '0; cy_q <= '0;
    end else begin
      if (cx_q + 11'(sx) <= w) begin
        cx_q <= cx_q + 11'(sx); spx_q <= cx_q + 11'(sx);
      end
      if (cy_q + 11'(sy) <= h) begin
        cy_q <= cy_q + 11'(sy); spy_q <= cy_q + 11'(sy);
      end
      if (restart_i) begin
        cx_q <= '0; cy_q <= '0; spx_q <= '0; spy_q <= '0;
      end
    end
  end
  assign spx = spx_q;
  assign spy = spy_q;

  // span is final once no further stride fits
  logic span_ok;
  assign span_ok = (cx_q + 11'(sx) > w) && (cy_q + 11'(sy) > h);

  // one item in the pipe at a time
  assign s_ready_o = (state_q == StRun) && !sts_i.full && !restart_i && span_ok;
  assign take = s_valid_i && s_ready_o;

  always_comb begin
    state_d = state_q;
    col_d = col_q; row_d = row_q; chn_d = chn_q;
    ox_d = ox_q; oy_d = oy_q; wx_d = wx_q;
    case (state_q)
      StRun:  if (take) state_d = StWait;
      StWait: if (!sts_i.busy) state_d = StRun;
      default: state_d = StRun;
    endcase
    if (take) begin
      if ({1'b0, ox_q} + 4'd1 >= sx) begin
        ox_d = '0; wx_d = wx_q + 1'b1;
      end else begin
        ox_d = ox_q + 3'd1;
      end
      if ({1'b0, col_q} + 11'd1 >= w) begin
        col_d = '0; ox_d = '0; wx_d = '0;
        if ({1'b0, oy_q} + 4'd1 >= sy) oy_d = '0;
        else oy_d = oy_q + 3'd1;
        if ({1'b0, row_q} + 11'd1 >= h) begin
          row_d = '0; oy_d = '0;
          chn_d = ({1'b0, chn_q} + 11'd1 >= ch) ? '0 : chn_q + 10'd1;
        end else begin
          row_d = row_q + 10'd1;
        end
      end else begin
        col_d = col_q + 10'd1;
      end
    end
    if (restart_i) begin
      col_d = '0; row_d = '0; chn_d = '0; ox_d = '0; oy_d = '0; wx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StRun;
      col_q <= '0; row_q <= '0; chn_q <= '0;
      ox_q <= '0; oy_q <= '0; wx_q <= '0;
    end else begin
      state_q <= state_d;
      col_q <= col_d; row_q <= row_d; chn_q <= chn_d;
      ox_q <= ox_d; oy_q <= oy_d; wx_q <= wx_d;
    end
  end

  logic pl;
  assign pl = ({1'b0, col_q} == spx - 11'd1) && ({1'b0, row_q} == spy - 11'd1);
  always_comb begin
    cmd_o.take      = take;
    cmd_o.in_win    = ({1'b0, col_q} < spx) && ({1'b0, row_q} < spy);
    cmd_o.wx        = wx_q;
    cmd_o.ox        = ox_q;
    cmd_o.oy        = oy_q;
    cmd_o.row_end   = ({1'b0, ox_q} == sx - 4'd1);
    cmd_o.col_first = (oy_q == '0);
    cmd_o.win_end   = cmd_o.row_end && ({1'b0, oy_q} == sy - 4'd1);
    cmd_o.pl        = pl;
    cmd_o.fl        = pl && ({1'b0, chn_q} == ch - 11'd1);
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("ctrl state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni) take |=> !s_ready_o)
    else $error("second item taken while one is in flight");
  assert property (@(posedge clk_i) disable iff (!rst_ni) ox_q < 3'(MaxStride - 1) ||
                   ox_q == 3'(MaxStride - 1))
    else $error("window phase out of range");
endmodule

>>> hdl/pool_dpath.sv
module pool_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pool_pkg::cfg_t               cfg_i,
  input  pool_pkg::cmd_t               cmd_i,
  input  logic signed [pool_pkg::SampleBits-1:0] sample_i,
  input  logic                         m_ready_i,
  output pool_pkg::sts_t               sts_o,
  output logic                         m_valid_o,
  output logic [15:0]                  pooled_o,
  output logic [2:0]                   xo_o,
  output logic [2:0]                   yo_o,
  output logic                         pl_o,
  output logic                         fl_o
);
  import pool_pkg::*;

  // stage 1: memory read; stage 2: update and write; stage 3: divide; out register
  logic [AccBits+5:0] mem [MaxWidth];
  logic [AccBits+5:0] rd_q;
  logic s1_q, s2_q, s3_q;
  cmd_t c1_q;
  logic signed [AccBits-1:0] smp1_q;
  logic signed [AccBits-1:0] racc_q;
  logic [2:0] rcol_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) rd_q <= mem[cmd_i.wx];
  end

  logic signed [AccBits-1:0] racc_d, ev, ev_new;
  logic [2:0] rcol_d, exo, eyo;
  logic wr;
  always_comb begin
    ev  = signed'(rd_q[AccBits+5:6]);
    racc_d = racc_q; rcol_d = rcol_q; ev_new = ev; exo = rd_q[5:3]; eyo = rd_q[2:0];
    wr = 1'b0;
    if (!cfg_i.mode) begin
      if (c1_q.ox == '0 || smp1_q > racc_q) begin
        racc_d = smp1_q; rcol_d = c1_q.ox;
      end
      if (c1_q.row_end && (c1_q.col_first || racc_d > ev)) begin
        ev_new = racc_d; exo = rcol_d; eyo = c1_q.oy;
      end
    end else begin
      racc_d = (c1_q.ox == '0) ? smp1_q : racc_q + smp1_q;
      if (c1_q.row_end) begin
        ev_new = c1_q.col_first ? racc_d : ev + racc_d;
        exo = '0; eyo = '0;
      end
    end
    wr = c1_q.row_end;
  end

  logic signed [AccBits-1:0] res2_q;
  logic [2:0] xo2_q, yo2_q;
  cmd_t c2_q;

  always_ff @(posedge clk_i) begin
    if (s1_q && c1_q.in_win) begin
      racc_q <= racc_d; rcol_q <= rcol_d;
      if (wr) mem[c1_q.wx] <= {ev_new, exo, eyo};
    end
    if (cmd_i.take) begin
      c1_q <= cmd_i;
      smp1_q <= AccBits'(sample_i);
    end
    if (s1_q) begin
      c2_q <= c1_q; res2_q <= ev_new; xo2_q <= exo; yo2_q <= eyo;
    end
  end

  // divider: restoring, one quotient bit per cycle on the magnitude
  localparam int DivSteps = AccBits;
  logic [AccBits-1:0] mag_q, rem_q;
  logic [6:0] area;
  logic [4:0] cnt_q;
  logic neg_q, div_q;
  logic [AccBits:0] trial;
  logic [3:0] sxc, syc;
  assign sxc = clamp4(cfg_i.sx);
  assign syc = clamp4(cfg_i.sy);
  assign area = 7'(sxc) * 7'(syc);
  assign trial = {rem_q, mag_q[AccBits-1]} - {{(AccBits-6){1'b0}}, area};

  logic out_v_q;
  logic [15:0] po_q;
  logic [2:0] xo_q, yo_q;
  logic pl_q, fl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0; s2_q <= 1'b0; s3_q <= 1'b0; div_q <= 1'b0; cnt_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      s1_q <= cmd_i.take;
      s2_q <= s1_q && c1_q.in_win && c1_q.win_end;
      if (out_v_q && m_ready_i) out_v_q <= 1'b0;
      if (s2_q) begin
        if (!cfg_i.mode) out_v_q <= 1'b1;
        else begin div_q <= 1'b1; cnt_q <= 5'(DivSteps - 1); end
      end
      if (div_q) begin
        if (cnt_q == '0) begin div_q <= 1'b0; out_v_q <= 1'b1; end
        else cnt_q <= cnt_q - 5'd1;
      end
      s3_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q) begin
      neg_q <= res2_q[AccBits-1];
      mag_q <= res2_q[AccBits-1] ? AccBits'(-res2_q) : res2_q;
      rem_q <= '0;
      po_q <= res2_q[15:0]; xo_q <= xo2_q; yo_q <= yo2_q;
      pl_q <= c2_q.pl; fl_q <= c2_q.fl;
    end
    if (div_q) begin
      if (!trial[AccBits]) begin
        rem_q <= trial[AccBits-1:0];
        mag_q <= {mag_q[AccBits-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[AccBits-2:0], mag_q[AccBits-1]};
        mag_q <= {mag_q[AccBits-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        if (!trial[AccBits])
          po_q <= neg_q ? 16'(-{mag_q[AccBits-2:0], 1'b1}) : 16'({mag_q[AccBits-2:0], 1'b1});
        else
          po_q <= neg_q ? 16'(-{mag_q[AccBits-2:0], 1'b0}) : 16'({mag_q[AccBits-2:0], 1'b0});
        xo_q <= '0; yo_q <= '0;
      end
    end
  end

  assign sts_o.busy = s1_q || s2_q || s3_q || div_q;
  assign sts_o.full = out_v_q;
  assign m_valid_o = out_v_q;
  assign pooled_o = po_q;
  assign xo_o = xo_q;
  assign yo_o = yo_q;
  assign pl_o = pl_q;
  assign fl_o = fl_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(s2_q && out_v_q))
    else $error("result produced while output register full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) s1_q |=> !s1_q)
    else $error("back to back items in datapath");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(div_q && s2_q))
    else $error("new window during divide");
endmodule

>>> hdl/pool2d_max_mean_stream.sv
// Streaming 2-D max/mean pooling over non-overlapping stride_x by stride_y windows.
// Samples enter in raster order per plane; each item passes through the line
// store read and update path, and in mean mode the item that closes a window
// also passes through the bit-serial divider. A new item is taken once the
// previous one has left the datapath and the output register is free.
// After reset and after a config write to a defined index (width through
// mode) the window span is stepped out one stride per cycle, and input waits
// until the span is final before the first item. Incomplete edge windows are
// dropped. A config write to a defined index restarts the frame.
module pool2d_max_mean_stream (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] sample
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [15:0] pooled, [18:16] x_offset, [21:19] y_offset
  output logic        m_axis_tlast_o,   // plane_last
  output logic        m_axis_tuser_o,   // frame_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);
  import pool_pkg::*;

  cfg_t cfg_q;
  logic cfg_wr, restart;
  cmd_t cmd;
  sts_t sts;
  logic [15:0] pooled;
  logic [2:0] xo, yo;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr = cfg_valid_i;
  assign restart = cfg_wr && (cfg_index_i <= CfgMode);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{w: 11'd32, h: 11'd32, sx: 4'd2, sy: 4'd2, ch: 11'd1, mode: 1'b0};
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CfgWidth:   cfg_q.w <= cfg_data_i;
        CfgHeight:  cfg_q.h <= cfg_data_i;
        CfgStrideX: cfg_q.sx <= cfg_data_i[3:0];
        CfgStrideY: cfg_q.sy <= cfg_data_i[3:0];
        CfgChan:    cfg_q.ch <= cfg_data_i;
        CfgMode:    cfg_q.mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  pool_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .restart_i(restart),
    .s_valid_i(s_axis_tvalid_i), .sts_i(sts), .s_ready_o(s_axis_tready_o), .cmd_o(cmd)
  );

  pool_dpath u_dpath (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .cmd_i(cmd), .sample_i(s_axis_tdata_i),
    .m_ready_i(m_axis_tready_i), .sts_o(sts), .m_valid_o(m_axis_tvalid_o),
    .pooled_o(pooled), .xo_o(xo), .yo_o(yo), .pl_o(m_axis_tlast_o), .fl_o(m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {2'b00, yo, xo, pooled};
endmodule
